FILE: src/ffsa_pkg.sv
package ffsa_pkg;

  localparam int WORD_W = 32;
  localparam int LEN_W = 33;
  localparam int SUM_W = 34;
  localparam logic [WORD_W-1:0] WORD_BYTES = 32'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOFIT   = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_OVERLAP = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    OP_LOW   = 2'd0,
    OP_STACK = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_REPORT,
    CMD_LOW,
    CMD_STACK,
    CMD_FREE
  } cmd_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [WORD_W-1:0] size;
    logic [WORD_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [WORD_W-1:0] result_address;
    logic [WORD_W-1:0] free_total;
  } out_item_t;

  typedef struct packed {
    cmd_e              kind;
    logic [2:0]        status;
    logic [LEN_W-1:0]  n;
    logic [WORD_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } seg_t;

  typedef struct packed {
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] limit;
  } heap_cfg_t;

endpackage

FILE: src/ffsa_fifo.sv
module ffsa_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ffsa_pkg::cmd_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  output ffsa_pkg::cmd_t data_o,
  input  logic          pop_i
);
  import ffsa_pkg::*;

  cmd_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

FILE: src/ffsa_front.sv
module ffsa_front #(
  parameter int GRANULE   = 8,
  parameter int ADDR_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ffsa_pkg::in_item_t  in_data_i,
  input  ffsa_pkg::heap_cfg_t cfg_i,
  output logic                push_o,
  output ffsa_pkg::cmd_t      push_data_o,
  input  logic                full_i
);
  import ffsa_pkg::*;

  localparam logic [WORD_W-1:0] ADDR_MAX =
      (ADDR_BITS >= 32) ? '1 : WORD_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [LEN_W-1:0] GRAN_MASK = LEN_W'(GRANULE - 1);

  logic             busy_q, busy_d;
  in_item_t         item_q, item_d;

  logic [LEN_W-1:0] n;
  logic [SUM_W-1:0] blk_end;
  cmd_t             cmd;

  assign in_stall_o = busy_q;

  always_comb begin
    // The granule is a power of two, so rounding up is an add and a mask.
    n = ({1'b0, item_q.size} + GRAN_MASK) & ~GRAN_MASK;
    blk_end = {2'b0, item_q.address} + {1'b0, n};
    cmd.n      = n;
    cmd.addr   = item_q.address;
    cmd.status = ST_OK;
    cmd.kind   = CMD_REPORT;
    if (op_e'(item_q.op) == OP_NONE) begin
      cmd.kind = CMD_REPORT;
    end else if (item_q.size == '0) begin
      cmd.status = ST_ZERO;
    end else begin
      case (op_e'(item_q.op))
        OP_LOW:   cmd.kind = CMD_LOW;
        OP_STACK: cmd.kind = CMD_STACK;
        OP_FREE: begin
          if (item_q.address < cfg_i.base || item_q.address > cfg_i.limit ||
              blk_end > {2'b0, ADDR_MAX}) begin
            cmd.status = ST_RANGE;
          end else begin
            cmd.kind = CMD_FREE;
          end
        end
        default: cmd.kind = CMD_REPORT;
      endcase
    end
  end

  assign push_data_o = cmd;
  assign push_o      = busy_q && !full_i;

  always_comb begin
    busy_d = busy_q;
    item_d = item_q;
    if (!busy_q) begin
      if (in_valid_i) begin
        busy_d = 1'b1;
        item_d = in_data_i;
      end
    end else if (!full_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

endmodule

FILE: src/ffsa_back.sv
module ffsa_back #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ffsa_pkg::heap_cfg_t  cfg_i,
  input  logic                 init_i,
  input  logic                 cmd_valid_i,
  input  ffsa_pkg::cmd_t       cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ffsa_pkg::out_item_t  out_data_o
);
  import ffsa_pkg::*;

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  seg_t mem_q [MAX_SEGMENTS];
  seg_t rdata_q;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  seg_t             wr_data;

  logic [2:0]        state_q, state_d;
  logic              init_q, init_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [LEN_W-1:0]  free_q, free_d;
  cmd_t              cmd_q, cmd_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              chk_q, chk_d;
  logic [IDX_W-1:0]  chk_idx_q, chk_idx_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  f_idx_q, f_idx_d;
  seg_t              f_q, f_d;
  logic              prev_valid_q, prev_valid_d;
  logic [IDX_W-1:0]  prev_idx_q, prev_idx_d;
  seg_t              prev_q, prev_d;
  logic [2:0]        res_status_q, res_status_d;
  logic [WORD_W-1:0] res_addr_q, res_addr_d;
  logic              sh_up_q, sh_up_d;
  logic [CNT_W-1:0]  sh_src_q, sh_src_d;
  logic [CNT_W-1:0]  sh_left_q, sh_left_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pend_dst_q, pend_dst_d;
  logic              ins_q, ins_d;
  logic [IDX_W-1:0]  ins_idx_q, ins_idx_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic             stop, issue;
  logic [CNT_W-1:0] ins_pt;
  logic [SUM_W-1:0] prev_end, blk_end, top;
  logic             ovl, join_p, join_n;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx];
    end
  end

  always_comb begin
    stop = chk_q && (((cmd_q.kind == CMD_LOW) && (rdata_q.len >= cmd_q.n)) ||
                     ((cmd_q.kind == CMD_FREE) && (rdata_q.start >= cmd_q.addr)));
    issue    = (scan_q < count_q) && !stop;
    ins_pt   = found_q ? CNT_W'(f_idx_q) : count_q;
    prev_end = {2'b0, prev_q.start} + {1'b0, prev_q.len};
    blk_end  = {2'b0, cmd_q.addr} + {1'b0, cmd_q.n};
    top      = {2'b0, f_q.start} + {1'b0, f_q.len};
    ovl      = (prev_valid_q && ({2'b0, cmd_q.addr} < prev_end)) ||
               (found_q && (blk_end > {2'b0, f_q.start}));
    join_p   = prev_valid_q && (prev_end == {2'b0, cmd_q.addr});
    join_n   = found_q && (blk_end == {2'b0, f_q.start});
  end

  always_comb begin
    state_d      = state_q;
    init_d       = init_q | init_i;
    count_d      = count_q;
    free_d       = free_q;
    cmd_d        = cmd_q;
    scan_d       = scan_q;
    chk_d        = chk_q;
    chk_idx_d    = chk_idx_q;
    found_d      = found_q;
    f_idx_d      = f_idx_q;
    f_d          = f_q;
    prev_valid_d = prev_valid_q;
    prev_idx_d   = prev_idx_q;
    prev_d       = prev_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    sh_up_d      = sh_up_q;
    sh_src_d     = sh_src_q;
    sh_left_d    = sh_left_q;
    pend_d       = pend_q;
    pend_dst_d   = pend_dst_q;
    ins_d        = ins_q;
    ins_idx_d    = ins_idx_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    pop_o        = 1'b0;
    rd_en        = 1'b0;
    rd_idx       = '0;
    wr_en        = 1'b0;
    wr_idx       = '0;
    wr_data      = '0;

    case (state_q)
      S_IDLE: begin
        if (init_q) begin
          init_d        = init_i;
          wr_en         = 1'b1;
          wr_data.start = cfg_i.base;
          wr_data.len   = {1'b0, cfg_i.limit} - {1'b0, cfg_i.base};
          if (cfg_i.limit > cfg_i.base) begin
            count_d = CNT_W'(1);
            free_d  = wr_data.len;
          end else begin
            count_d = '0;
            free_d  = '0;
          end
        end else if (cmd_valid_i && !out_valid_q) begin
          pop_o        = 1'b1;
          cmd_d        = cmd_i;
          scan_d       = '0;
          chk_d        = 1'b0;
          found_d      = 1'b0;
          prev_valid_d = 1'b0;
          res_status_d = cmd_i.status;
          res_addr_d   = '0;
          state_d      = (cmd_i.kind == CMD_REPORT) ? S_DONE : S_SCAN;
        end
      end

      S_SCAN: begin
        // One read issued per cycle; the entry read last cycle is checked now.
        if (chk_q) begin
          if (cmd_q.kind == CMD_FREE) begin
            if (rdata_q.start >= cmd_q.addr) begin
              found_d = 1'b1;
              f_idx_d = chk_idx_q;
              f_d     = rdata_q;
            end else begin
              prev_valid_d = 1'b1;
              prev_idx_d   = chk_idx_q;
              prev_d       = rdata_q;
            end
          end else if (rdata_q.len >= cmd_q.n) begin
            found_d = 1'b1;
            f_idx_d = chk_idx_q;
            f_d     = rdata_q;
          end
        end
        chk_d = issue;
        if (issue) begin
          rd_en     = 1'b1;
          rd_idx    = scan_q[IDX_W-1:0];
          chk_idx_d = scan_q[IDX_W-1:0];
          scan_d    = scan_q + CNT_W'(1);
        end
        if (stop || (!chk_q && (scan_q == count_q))) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_d = S_DONE;
        pend_d  = 1'b0;
        if (cmd_q.kind == CMD_FREE) begin
          if (ovl) begin
            res_status_d = ST_OVERLAP;
          end else if (join_p && join_n) begin
            wr_en         = 1'b1;
            wr_idx        = prev_idx_q;
            wr_data.start = prev_q.start;
            wr_data.len   = prev_q.len + cmd_q.n + f_q.len;
            free_d        = free_q + cmd_q.n;
            ins_d         = 1'b0;
            sh_up_d       = 1'b0;
            sh_src_d      = CNT_W'(f_idx_q) + CNT_W'(1);
            sh_left_d     = count_q - CNT_W'(1) - CNT_W'(f_idx_q);
            state_d       = S_SHIFT;
          end else if (join_p) begin
            wr_en         = 1'b1;
            wr_idx        = prev_idx_q;
            wr_data.start = prev_q.start;
            wr_data.len   = prev_q.len + cmd_q.n;
            free_d        = free_q + cmd_q.n;
          end else if (join_n) begin
            wr_en         = 1'b1;
            wr_idx        = f_idx_q;
            wr_data.start = cmd_q.addr;
            wr_data.len   = f_q.len + cmd_q.n;
            free_d        = free_q + cmd_q.n;
          end else if (count_q >= CNT_W'(MAX_SEGMENTS)) begin
            res_status_d = ST_FULL;
          end else begin
            free_d    = free_q + cmd_q.n;
            ins_d     = 1'b1;
            ins_idx_d = ins_pt[IDX_W-1:0];
            sh_up_d   = 1'b1;
            sh_src_d  = count_q - CNT_W'(1);
            sh_left_d = count_q - ins_pt;
            state_d   = S_SHIFT;
          end
        end else if (!found_q) begin
          res_status_d = ST_NOFIT;
        end else begin
          free_d = free_q - cmd_q.n;
          if (cmd_q.kind == CMD_LOW) begin
            res_addr_d = f_q.start;
          end else begin
            res_addr_d = WORD_W'(top - SUM_W'(WORD_BYTES));
          end
          if (f_q.len == cmd_q.n) begin
            ins_d     = 1'b0;
            sh_up_d   = 1'b0;
            sh_src_d  = CNT_W'(f_idx_q) + CNT_W'(1);
            sh_left_d = count_q - CNT_W'(1) - CNT_W'(f_idx_q);
            state_d   = S_SHIFT;
          end else begin
            wr_en  = 1'b1;
            wr_idx = f_idx_q;
            if (cmd_q.kind == CMD_LOW) begin
              wr_data.start = f_q.start + cmd_q.n[WORD_W-1:0];
            end else begin
              wr_data.start = f_q.start;
            end
            wr_data.len = f_q.len - cmd_q.n;
          end
        end
      end

      S_SHIFT: begin
        // Read one entry and write the one read last cycle to its new place.
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_idx  = pend_dst_q;
          wr_data = rdata_q;
        end
        pend_d = (sh_left_q != '0);
        if (sh_left_q != '0) begin
          rd_en      = 1'b1;
          rd_idx     = sh_src_q[IDX_W-1:0];
          pend_dst_d = sh_up_q ? IDX_W'(sh_src_q + CNT_W'(1)) :
                                 IDX_W'(sh_src_q - CNT_W'(1));
          sh_src_d   = sh_up_q ? sh_src_q - CNT_W'(1) : sh_src_q + CNT_W'(1);
          sh_left_d  = sh_left_q - CNT_W'(1);
        end else if (!pend_q) begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (ins_q) begin
          wr_en         = 1'b1;
          wr_idx        = ins_idx_q;
          wr_data.start = cmd_q.addr;
          wr_data.len   = cmd_q.n;
          count_d       = count_q + CNT_W'(1);
        end else begin
          count_d = count_q - CNT_W'(1);
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        out_valid_d          = 1'b1;
        out_d.status         = res_status_q;
        out_d.result_address = (res_status_q == ST_OK) ? res_addr_q : '0;
        out_d.free_total     = free_q[LEN_W-1] ? '1 : free_q[WORD_W-1:0];
        state_d              = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    chk_idx_q    <= chk_idx_d;
    f_idx_q      <= f_idx_d;
    f_q          <= f_d;
    prev_idx_q   <= prev_idx_d;
    prev_q       <= prev_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    sh_up_q      <= sh_up_d;
    sh_src_q     <= sh_src_d;
    pend_dst_q   <= pend_dst_d;
    ins_idx_q    <= ins_idx_d;
    out_q        <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      init_q       <= 1'b1;
      count_q      <= '0;
      free_q       <= '0;
      scan_q       <= '0;
      chk_q        <= 1'b0;
      found_q      <= 1'b0;
      prev_valid_q <= 1'b0;
      sh_left_q    <= '0;
      pend_q       <= 1'b0;
      ins_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      init_q       <= init_d;
      count_q      <= count_d;
      free_q       <= free_d;
      scan_q       <= scan_d;
      chk_q        <= chk_d;
      found_q      <= found_d;
      prev_valid_q <= prev_valid_d;
      sh_left_q    <= sh_left_d;
      pend_q       <= pend_d;
      ins_q        <= ins_d;
      out_valid_q  <= out_valid_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count exceeds table size");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!out_valid_q && state_q == S_IDLE && !init_q))
    else $error("command taken while result slot busy");

  a_done_sets_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> out_valid_q)
    else $error("finished command produced no result");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && ins_q) |-> (count_q < CNT_W'(MAX_SEGMENTS)))
    else $error("insert into full table");

endmodule

FILE: src/first_fit_segment_allocator_top.sv
// From input transfer to result: the front registers the item to round and classify it, the
// command queue passes it on, and the back scans the table at one entry a cycle, then
// shifts entries at one entry a cycle when a segment is removed or inserted. The back
// takes one command at a time, and the next only once the result slot is empty; the
// front and the command queue can hold further items meanwhile. Reset, and any
// configuration write, rebuild the table as one heap segment (none if limit <= base).
module first_fit_segment_allocator_top #(
  parameter int MAX_SEGMENTS = 64,
  parameter int GRANULE      = 8,
  parameter int ADDR_BITS    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ffsa_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ffsa_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);
  import ffsa_pkg::*;

  localparam logic [WORD_W-1:0] ADDR_MAX =
      (ADDR_BITS >= 32) ? '1 : WORD_W'((64'd1 << ADDR_BITS) - 64'd1);

  heap_cfg_t cfg_q;
  logic      push, full, cmd_valid, pop;
  cmd_t      push_data, cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base  <= '0;
      cfg_q.limit <= 32'd65536 & ADDR_MAX;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_HEAP_BASE) begin
        cfg_q.base <= cfg_data_i & ADDR_MAX;
      end else begin
        cfg_q.limit <= cfg_data_i & ADDR_MAX;
      end
    end
  end

  ffsa_front #(
    .GRANULE  (GRANULE),
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  ffsa_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .valid_o    (cmd_valid),
    .data_o     (cmd),
    .pop_i      (pop)
  );

  ffsa_back #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .init_i     (cfg_we_i),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
